// ===== sv/plgc_pkg.sv =====
// Package: shared types, alert codes, register indexes and reset constants of the pump guard.
`timescale 1ns / 1ps
package plgc_pkg;

  localparam logic [31:0] RUN_LIMIT_DEFAULT_MS = 32'd600000;
  localparam logic [31:0] REST_MIN_DEFAULT_MS  = 32'd60000;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUMP_TIMEOUT  = 2'd0,
    REG_PUMP_MIN_OFF  = 2'd1,
    REG_RELAY_ACT_LOW = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ALERT_NONE    = 2'd0,
    ALERT_DRY     = 2'd1,
    ALERT_TIMEOUT = 2'd2,
    ALERT_SENSOR  = 2'd3
  } alert_t;

  typedef struct packed {
    logic        main_high;
    logic        main_low;
    logic        aux_high;
    logic        aux_mid;
    logic        aux_low;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       pump_running;
    logic       relay_level;
    logic [1:0] alert_code;
    logic       timeout_latched;
    logic       report_now;
  } out_item_t;

  typedef struct packed {
    logic [31:0] run_limit_ms;
    logic [31:0] rest_min_ms;
    logic        relay_active_low;
  } cfg_t;

endpackage

// ===== sv/plgc_cfg_regs.sv =====
// Configuration register file: timeout, minimum off time and relay polarity.
`timescale 1ns / 1ps
module plgc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [plgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data,
  output plgc_pkg::cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_limit_ms     <= plgc_pkg::RUN_LIMIT_DEFAULT_MS;
      cfg.rest_min_ms      <= plgc_pkg::REST_MIN_DEFAULT_MS;
      cfg.relay_active_low <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        plgc_pkg::REG_PUMP_TIMEOUT:  cfg.run_limit_ms     <= cfg_data;
        plgc_pkg::REG_PUMP_MIN_OFF:  cfg.rest_min_ms      <= cfg_data;
        plgc_pkg::REG_RELAY_ACT_LOW: cfg.relay_active_low <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/plgc_core.sv =====
// Decision core: pump and alert state registers and the per-item guard rules.
`timescale 1ns / 1ps
module plgc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  plgc_pkg::in_item_t  item,
  input  plgc_pkg::cfg_t      cfg,
  output plgc_pkg::out_item_t result
);

  logic                 pump_on, pump_on_next;
  plgc_pkg::alert_t     active_alert, active_alert_next;
  logic                 timeout_lock, timeout_lock_next;
  logic [31:0]          start_time, start_time_next;
  logic [31:0]          stop_time, stop_time_next;
  logic                 has_stopped, has_stopped_next;

  logic                 bad;
  logic [31:0]          run_ms;
  logic [31:0]          rest_ms;
  logic                 timed_out;
  logic                 rested;
  logic                 stop_req;
  plgc_pkg::alert_t     alert_mid;

  assign bad = (item.main_high && !item.main_low) || (item.aux_high && !item.aux_mid) ||
               (item.aux_mid && !item.aux_low);
  assign run_ms    = item.now_ms - start_time;
  assign rest_ms   = item.now_ms - stop_time;
  assign timed_out = run_ms > cfg.run_limit_ms;
  assign rested    = !has_stopped || (rest_ms > cfg.rest_min_ms);

  always_comb begin
    pump_on_next      = pump_on;
    active_alert_next = active_alert;
    timeout_lock_next = timeout_lock;
    start_time_next   = start_time;
    stop_time_next    = stop_time;
    has_stopped_next  = has_stopped;
    stop_req          = 1'b0;
    alert_mid         = active_alert;

    if (bad) begin
      stop_req          = pump_on;
      active_alert_next = plgc_pkg::ALERT_SENSOR;
    end else begin
      // a coherent reading clears a sensor fault before the other rules
      if (active_alert == plgc_pkg::ALERT_SENSOR) alert_mid = plgc_pkg::ALERT_NONE;
      active_alert_next = alert_mid;
      if (!item.aux_low) begin
        if (pump_on) begin
          stop_req          = 1'b1;
          active_alert_next = plgc_pkg::ALERT_DRY;
        end
      end else begin
        if (alert_mid == plgc_pkg::ALERT_DRY) active_alert_next = plgc_pkg::ALERT_NONE;
        if (pump_on) begin
          if (item.main_high) begin
            stop_req = 1'b1;
          end else if (timed_out) begin
            stop_req          = 1'b1;
            timeout_lock_next = 1'b1;
            active_alert_next = plgc_pkg::ALERT_TIMEOUT;
          end
        end else if (timeout_lock) begin
          if (item.main_high) begin
            timeout_lock_next = 1'b0;
            active_alert_next = plgc_pkg::ALERT_NONE;
          end
        end else if (!item.main_low && rested) begin
          pump_on_next    = 1'b1;
          start_time_next = item.now_ms;
        end
      end
    end

    if (stop_req) begin
      pump_on_next     = 1'b0;
      stop_time_next   = item.now_ms;
      has_stopped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_on      <= 1'b0;
      active_alert <= plgc_pkg::ALERT_NONE;
      timeout_lock <= 1'b0;
      start_time   <= '0;
      stop_time    <= '0;
      has_stopped  <= 1'b0;
    end else if (advance) begin
      pump_on      <= pump_on_next;
      active_alert <= active_alert_next;
      timeout_lock <= timeout_lock_next;
      start_time   <= start_time_next;
      stop_time    <= stop_time_next;
      has_stopped  <= has_stopped_next;
    end
  end

  // an alert or pump change is reported; the final value differs iff any step changed it
  assign result.pump_running    = pump_on_next;
  assign result.relay_level     = pump_on_next ^ cfg.relay_active_low;
  assign result.alert_code      = active_alert_next;
  assign result.timeout_latched = timeout_lock_next;
  assign result.report_now      = (pump_on_next != pump_on) ||
                                  (active_alert_next != active_alert);

endmodule

// ===== sv/pump_level_guard_controller.sv =====
// Top level: input register, decision core, result register and configuration port.
// Path: an item passes from the input register through the combinational core into the
//   result register, and is held while out_valid is high and out_ready is low.
// Throughput: one item per clock while out_ready is high; the state loop closes through the core's registers.
// Reset (rst, synchronous): pump off, no alert, no timeout latch, never stopped,
//   registers at their default values, both pipeline stages empty.
`timescale 1ns / 1ps
module pump_level_guard_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  plgc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output plgc_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [plgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  plgc_pkg::cfg_t      cfg;
  plgc_pkg::in_item_t  in_q;
  logic                in_q_valid;
  plgc_pkg::out_item_t result;
  logic                advance;

  plgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // move the held item through the core when the result register can take it
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  plgc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  a_relay_polarity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.relay_level == (out_data.pump_running ^ cfg.relay_active_low)))
    else $error("relay level does not follow pump state and polarity");

  a_timeout_latched: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.alert_code == plgc_pkg::ALERT_TIMEOUT)) |->
      (out_data.timeout_latched && !out_data.pump_running))
    else $error("timeout alert without latch or with pump running");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register empty after a transfer through the core");

endmodule
